FILE: hdl/thread_ready_suspend_table_assert.svh
// assertion macros for the thread table rtl
// expects signals clk and rst in the scope of each use
`ifndef THREAD_READY_SUSPEND_TABLE_ASSERT_SVH
`define THREAD_READY_SUSPEND_TABLE_ASSERT_SVH

// condition in the same cycle
`define TRST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition in the following cycle
`define TRST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/trst_pkg.sv
// shared types and constants of the thread ready/suspend table
// no dependencies
package trst_pkg;

  // sizes
  localparam int unsigned MAX_THREADS_DEFAULT = 16;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // highest id ever handed out
  localparam logic [ID_W-1:0] LAST_ID = 8'hFF;

  // configuration register indexes
  localparam logic [PADDR_W-3:0] REG_SLOTS_IN_USE = 1'b0;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // operation codes
  typedef enum logic [1:0] {
    OP_CREATE    = 2'd0,
    OP_SUSPEND   = 2'd1,
    OP_UNSUSPEND = 2'd2
  } op_t;

  // command transaction
  typedef struct packed {
    logic [1:0]        operation;
    logic [ID_W-1:0]   thread_id;
    logic [PRIO_W-1:0] priority_req;
    logic [ID_W-1:0]   current_id;
  } cmd_t;

  // result transaction
  typedef struct packed {
    logic             status;
    logic [ID_W-1:0]  new_id;
    logic [CNT_W-1:0] ready_count;
    logic [CNT_W-1:0] suspended_count;
  } result_t;

  // one table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              susp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/thread_ready_suspend_table.sv
// Thread table: ordered ready region from slot 0 up, suspended region from the top down.
// Create: latched in idle, checked and written in check, result registered in report.
// Suspend/unsuspend: the table ram is walked once to search and once to shift, one entry
// per cycle, then the entry is placed. One command at a time.
// Results cannot be stalled. Reset: slots_in_use min(MAX_THREADS, 16), both regions empty, no ram clear.
// depends on trst_pkg, trst_ram and thread_ready_suspend_table_assert.svh
`include "thread_ready_suspend_table_assert.svh"

module thread_ready_suspend_table #(
  parameter int unsigned MAX_THREADS = trst_pkg::MAX_THREADS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  trst_pkg::cmd_t                cmd,
  output logic                          done,
  output trst_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trst_pkg::PADDR_W-1:0]  paddr,
  input  logic [trst_pkg::PDATA_W-1:0]  pwdata,
  output logic [trst_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned ADDR_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int unsigned CW = trst_pkg::CNT_W;
  localparam logic [CW-1:0] RESET_SLOTS = CW'((MAX_THREADS < 16) ? MAX_THREADS : 16);
  localparam logic [7:0] MAX_SLOTS = 8'(MAX_THREADS);

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SEARCH, ST_SHIFT, ST_PLACE, ST_REPORT
  } state_t;

  state_t                           state;
  logic [CW-1:0]                    slots;
  logic [CW-1:0]                    ready_top;
  logic [CW-1:0]                    susp_base;
  logic [trst_pkg::ID_W-1:0]        last_id;
  logic [1:0]                       op_q;
  logic [trst_pkg::ID_W-1:0]        who_q;
  logic [trst_pkg::PRIO_W-1:0]      prio_q;
  logic [trst_pkg::ID_W-1:0]        cur_q;
  logic [CW-1:0]                    scan;
  logic [CW-1:0]                    search_end;
  logic                             rd_pend;
  logic [CW-1:0]                    rd_idx;
  trst_pkg::entry_t                 moved;
  logic                             ok_q;
  logic [trst_pkg::ID_W-1:0]        given_q;

  logic [trst_pkg::ENTRY_W-1:0]     ram_rdata;
  logic [trst_pkg::ENTRY_W-1:0]     ram_wdata;
  trst_pkg::entry_t                 rd_entry;
  trst_pkg::entry_t                 wr_entry;
  logic                             wr_en;
  logic [CW-1:0]                    wr_slot;
  logic [CW-1:0]                    rd_slot;
  logic [CW:0]                      scan_plus;
  logic                             search_issue;
  logic                             shift_issue;
  logic                             hit;
  logic                             create_ok;
  logic                             susp_ok;
  logic                             unsusp_ok;
  logic                             cfg_wr;
  logic                             cfg_sel;
  logic [CW-1:0]                    cfg_val;
  logic                             cfg_fits;

  // configuration port
  assign pready   = 1'b1;
  assign cfg_sel  = (paddr[trst_pkg::PADDR_W-1:2] == trst_pkg::REG_SLOTS_IN_USE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_val  = pwdata[CW-1:0];
  assign cfg_fits = ({3'b000, cfg_val} <= MAX_SLOTS);
  assign prdata   = cfg_sel ? trst_pkg::PDATA_W'(slots) : '0;

  assign busy = (state != ST_IDLE);

  // admission checks on the latched command
  assign create_ok = (slots != '0) && (ready_top < slots) && (ready_top < susp_base) &&
                     (last_id != trst_pkg::LAST_ID);
  assign susp_ok   = (slots != '0) && (cur_q != '0) && (ready_top != '0) &&
                     (susp_base != '0);
  assign unsusp_ok = (slots != '0) && (cur_q != '0) && (susp_base < slots) &&
                     (ready_top < slots);

  // walk control: search scans upward, shift moves toward the hole
  assign rd_entry     = trst_pkg::entry_t'(ram_rdata);
  assign hit          = rd_pend && (rd_entry.id == who_q);
  assign scan_plus    = {1'b0, scan} + (CW+1)'(1);
  assign search_issue = (scan < search_end);
  assign shift_issue  = (op_q == trst_pkg::OP_SUSPEND) ? (scan_plus < {1'b0, ready_top})
                                                       : (scan > susp_base);

  // read address
  always_comb begin
    rd_slot = scan;
    if (state == ST_SHIFT) begin
      rd_slot = (op_q == trst_pkg::OP_SUSPEND) ? scan_plus[CW-1:0] : scan - CW'(1);
    end
  end

  // write port select
  always_comb begin
    wr_en    = 1'b0;
    wr_slot  = rd_idx;
    wr_entry = rd_entry;
    unique case (state)
      ST_CHECK: begin
        if ((op_q == trst_pkg::OP_CREATE) && create_ok) begin
          wr_en    = 1'b1;
          wr_slot  = ready_top;
          wr_entry = '{id: last_id + 8'd1, prio: prio_q, susp: 1'b0};
        end
      end
      ST_SHIFT: begin
        wr_en = rd_pend;
      end
      ST_PLACE: begin
        wr_en = 1'b1;
        if (op_q == trst_pkg::OP_SUSPEND) begin
          wr_slot  = susp_base - CW'(1);
          wr_entry = '{id: moved.id, prio: moved.prio, susp: 1'b1};
        end else begin
          wr_slot  = ready_top;
          wr_entry = '{id: moved.id, prio: moved.prio, susp: 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_wdata = wr_entry;

  // entry storage
  trst_ram #(
    .WIDTH (trst_pkg::ENTRY_W),
    .DEPTH (MAX_THREADS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_t'(wr_slot)),
    .wdata (ram_wdata),
    .raddr (addr_t'(rd_slot)),
    .rdata (ram_rdata)
  );

  // sequencer, region counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slots     <= RESET_SLOTS;
      ready_top <= '0;
      susp_base <= RESET_SLOTS;
      last_id   <= '0;
      rd_pend   <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op_q   <= cmd.operation;
            who_q  <= (cmd.thread_id == '0) ? cmd.current_id : cmd.thread_id;
            prio_q <= cmd.priority_req;
            cur_q  <= cmd.current_id;
            state  <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          ok_q    <= 1'b0;
          given_q <= '0;
          rd_pend <= 1'b0;
          state   <= ST_REPORT;
          unique case (op_q)
            trst_pkg::OP_CREATE: begin
              if (create_ok) begin
                ok_q      <= 1'b1;
                given_q   <= last_id + 8'd1;
                last_id   <= last_id + 8'd1;
                ready_top <= ready_top + CW'(1);
              end
            end
            trst_pkg::OP_SUSPEND: begin
              if (susp_ok) begin
                scan       <= '0;
                search_end <= ready_top;
                state      <= ST_SEARCH;
              end
            end
            trst_pkg::OP_UNSUSPEND: begin
              if (unsusp_ok) begin
                scan       <= susp_base;
                search_end <= slots;
                state      <= ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SEARCH: begin
          if (hit) begin
            moved   <= rd_entry;
            scan    <= rd_idx;
            rd_pend <= 1'b0;
            state   <= ST_SHIFT;
          end else if (!rd_pend && !search_issue) begin
            state <= ST_REPORT;
          end else begin
            rd_pend <= search_issue;
            rd_idx  <= scan;
            if (search_issue) begin
              scan <= scan + CW'(1);
            end
          end
        end
        ST_SHIFT: begin
          rd_pend <= shift_issue;
          rd_idx  <= scan;
          if (shift_issue) begin
            scan <= (op_q == trst_pkg::OP_SUSPEND) ? scan + CW'(1) : scan - CW'(1);
          end
          if (!rd_pend && !shift_issue) begin
            state <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          ok_q <= 1'b1;
          if (op_q == trst_pkg::OP_SUSPEND) begin
            ready_top <= ready_top - CW'(1);
            susp_base <= susp_base - CW'(1);
          end else begin
            ready_top <= ready_top + CW'(1);
            susp_base <= susp_base + CW'(1);
          end
          state <= ST_REPORT;
        end
        ST_REPORT: begin
          done                   <= 1'b1;
          result.status          <= ok_q ? trst_pkg::STATUS_OK : trst_pkg::STATUS_REFUSED;
          result.new_id          <= given_q;
          result.ready_count     <= ready_top;
          result.suspended_count <= slots - susp_base;
          state                  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // capacity write empties the table
      if (cfg_wr && cfg_sel && cfg_fits) begin
        slots     <= cfg_val;
        ready_top <= '0;
        susp_base <= cfg_val;
      end
    end
  end

  // checks
  `TRST_ASSERT_NOW(a_regions_fit, 1'b1, (ready_top <= susp_base) && (susp_base <= slots),
    "ready and suspended regions overlap or exceed capacity")
  `TRST_ASSERT_NOW(a_write_in_table, wr_en, wr_slot < slots,
    "table write outside the slots in use")
  `TRST_ASSERT_NEXT(a_single_strobe, done, !done,
    "result strobe held for more than one cycle")
  `TRST_ASSERT_NOW(a_new_id_latest, done && (result.new_id != '0), result.new_id == last_id,
    "reported id differs from the last id handed out")
  `TRST_ASSERT_NEXT(a_busy_after_start, start && !busy, busy && !done,
    "command accepted without the sequencer starting")

endmodule

FILE: hdl/trst_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module trst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sim/testbench.sv
// self-checking testbench for thread_ready_suspend_table: directed and random commands,
// apb register writes and reads, each result checked against a local model of the table
// depends on trst_pkg and the rtl of thread_ready_suspend_table
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import trst_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_THREADS_DEFAULT;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 60;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [PADDR_W-1:0] SLOTS_ADDR = {REG_SLOTS_IN_USE, 2'b00};

  // dut ports
  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  cmd_t               cmd = '0;
  logic               done;
  result_t            result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // local copy of the thread table
  entry_t          thread_slots [];
  int unsigned     slot_limit = TABLE_DEPTH;
  int unsigned     ready_top = 0;
  int unsigned     susp_base = TABLE_DEPTH;
  logic [ID_W-1:0] last_id = '0;

  // results still owed by the block, oldest first
  result_t     awaited_results [$];
  result_t     oldest_result;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned burst_left = 0;

  thread_ready_suspend_table #(.MAX_THREADS(TABLE_DEPTH)) uut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // table model: applies one command and returns the result it produces
  function automatic result_t predict_table_op(input cmd_t c);
    result_t         r;
    logic [ID_W-1:0] who;
    entry_t          moved;
    int unsigned     i;
    int unsigned     k;
    logic            ok;
    ok = 1'b0;
    r = '0;
    who = (c.thread_id == '0) ? c.current_id : c.thread_id;
    case (c.operation)
      OP_CREATE: begin
        if (slot_limit != 0 && ready_top < slot_limit && ready_top < susp_base &&
            last_id != LAST_ID) begin
          last_id = last_id + ID_W'(1);
          thread_slots[ready_top] = '{id: last_id, prio: c.priority_req, susp: 1'b0};
          ready_top++;
          r.new_id = last_id;
          ok = 1'b1;
        end
      end
      OP_SUSPEND: begin
        // search the ready region, close the hole, push onto the suspended front
        if (slot_limit != 0 && c.current_id != '0 && ready_top != 0 && susp_base != 0) begin
          i = 0;
          while (i < ready_top && thread_slots[i].id != who) i++;
          if (i < ready_top) begin
            moved = thread_slots[i];
            for (k = i; k + 1 < ready_top; k++) thread_slots[k] = thread_slots[k + 1];
            ready_top--;
            susp_base--;
            moved.susp = 1'b1;
            thread_slots[susp_base] = moved;
            ok = 1'b1;
          end
        end
      end
      OP_UNSUSPEND: begin
        // search the suspended region, close the hole, append to the ready end
        if (slot_limit != 0 && c.current_id != '0 && susp_base < slot_limit &&
            ready_top < slot_limit) begin
          i = susp_base;
          while (i < slot_limit && thread_slots[i].id != who) i++;
          if (i < slot_limit) begin
            moved = thread_slots[i];
            for (k = i; k > susp_base; k--) thread_slots[k] = thread_slots[k - 1];
            susp_base++;
            moved.susp = 1'b0;
            thread_slots[ready_top] = moved;
            ready_top++;
            ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.status = ok ? STATUS_OK : STATUS_REFUSED;
    r.ready_count = CNT_W'(ready_top);
    r.suspended_count = CNT_W'(slot_limit - susp_base);
    return r;
  endfunction

  // register write effect: out-of-range capacities are dropped
  function automatic void apply_slot_write(input logic [PDATA_W-1:0] data);
    if (int'(data[CNT_W-1:0]) <= TABLE_DEPTH) begin
      slot_limit = 32'(data[CNT_W-1:0]);
      ready_top = 0;
      susp_base = slot_limit;
    end
  endfunction

  function automatic cmd_t make_cmd(input op_t op, input logic [ID_W-1:0] tid,
                                    input logic [PRIO_W-1:0] prio,
                                    input logic [ID_W-1:0] cur);
    cmd_t c;
    c.operation = op;
    c.thread_id = tid;
    c.priority_req = prio;
    c.current_id = cur;
    return c;
  endfunction

  // mostly legal moves on live ids, the rest unconstrained noise
  function automatic cmd_t random_cmd();
    cmd_t            c;
    int unsigned     pick;
    logic [ID_W-1:0] target;
    c.operation = OP_CREATE;
    c.thread_id = ID_W'($urandom_range(0, 255));
    c.priority_req = PRIO_W'($urandom_range(0, 255));
    c.current_id = ID_W'($urandom_range(1, 255));
    if ($urandom_range(0, 3) == 0) begin
      c.operation = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) c.current_id = '0;
      return c;
    end
    pick = $urandom_range(0, 99);
    if (ready_top + slot_limit - susp_base < slot_limit && last_id != LAST_ID && pick < 30) begin
      return c;
    end else if (ready_top != 0 && (susp_base == slot_limit || pick < 65)) begin
      c.operation = OP_SUSPEND;
      target = thread_slots[$urandom_range(0, ready_top - 1)].id;
    end else if (susp_base < slot_limit) begin
      c.operation = OP_UNSUSPEND;
      target = thread_slots[$urandom_range(susp_base, slot_limit - 1)].id;
    end else begin
      return c;
    end
    // name the thread directly or through the running thread
    if ($urandom_range(0, 3) == 0) begin
      c.thread_id = '0;
      c.current_id = target;
    end else begin
      c.thread_id = target;
    end
    return c;
  endfunction

  // send one command transaction, then idle for a random gap that may be zero
  task automatic send_cmd(input cmd_t c);
    int unsigned gap;
    int unsigned r;
    cmd <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    awaited_results.push_back(predict_table_op(c));
    gap = 0;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) burst_left = $urandom_range(10, 40);
      if (r < 45) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(30, 80);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every result is in and the block is free
  task automatic wait_idle();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // apb write to the capacity register, then the bus returns to idle
  task automatic reg_write(input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SLOTS_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    apply_slot_write(data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // apb read of the capacity register, compared with the model
  task automatic reg_check();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= SLOTS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== PDATA_W'(slot_limit)) begin
      $display("%0t: slots_in_use read mismatch, expected %0d, actual %0h",
               $time, slot_limit, prdata);
      mismatch_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [ID_W-1:0] exp_v,
                                      input logic [ID_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %p", $time, result);
        mismatch_count++;
      end else begin
        oldest_result = awaited_results.pop_front();
        check_field("status", ID_W'(oldest_result.status), ID_W'(result.status));
        check_field("new_id", oldest_result.new_id, result.new_id);
        check_field("ready_count", ID_W'(oldest_result.ready_count),
                    ID_W'(result.ready_count));
        check_field("suspended_count", ID_W'(oldest_result.suspended_count),
                    ID_W'(result.suspended_count));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || done === 1'b1 || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // capacity register comes out of reset at full size
  task automatic test_reset_state();
    reg_check();
  endtask

  // suspend, unsuspend and an unknown op on an empty table
  task automatic test_empty_table();
    send_cmd(make_cmd(op_t'(2'b11), 8'd0, 8'd0, 8'd1));
    send_cmd(make_cmd(OP_SUSPEND, 8'd0, 8'd0, 8'd5));
    send_cmd(make_cmd(OP_UNSUSPEND, 8'd7, 8'd0, 8'd7));
  endtask

  // creates with priorities 00, FF and A5, ids 1 to 3
  task automatic test_create();
    send_cmd(make_cmd(OP_CREATE, 8'd0, 8'h00, 8'd0));
    send_cmd(make_cmd(OP_CREATE, 8'hFF, 8'hFF, 8'hFF));
    send_cmd(make_cmd(OP_CREATE, 8'h5A, 8'hA5, 8'h00));
  endtask

  // suspend: no running thread, via current id, unknown id, end and front of region
  task automatic test_suspend();
    send_cmd(make_cmd(OP_SUSPEND, 8'd3, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_SUSPEND, 8'd0, 8'd0, 8'd2));
    send_cmd(make_cmd(OP_SUSPEND, 8'd9, 8'd0, 8'd1));
    send_cmd(make_cmd(OP_SUSPEND, 8'd3, 8'd0, 8'd1));
    send_cmd(make_cmd(OP_SUSPEND, 8'd1, 8'd0, 8'hFF));
    send_cmd(make_cmd(OP_SUSPEND, 8'hFF, 8'd0, 8'hFF));
  endtask

  // unsuspend: via current id, not suspended, no running thread, by id, unknown op
  task automatic test_unsuspend();
    send_cmd(make_cmd(OP_UNSUSPEND, 8'd0, 8'd0, 8'd3));
    send_cmd(make_cmd(OP_UNSUSPEND, 8'd3, 8'd0, 8'd1));
    send_cmd(make_cmd(OP_UNSUSPEND, 8'd2, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_UNSUSPEND, 8'd2, 8'd0, 8'h80));
    send_cmd(make_cmd(op_t'(2'b11), 8'd1, 8'hFF, 8'd1));
  endtask

  // zero capacity refuses everything; oversized writes leave the register alone
  task automatic test_no_table();
    wait_idle();
    reg_write(32'd0);
    reg_check();
    send_cmd(make_cmd(OP_CREATE, 8'd0, 8'd7, 8'd0));
    send_cmd(make_cmd(OP_SUSPEND, 8'd0, 8'd0, 8'd3));
    send_cmd(make_cmd(OP_UNSUSPEND, 8'd3, 8'd0, 8'd3));
    wait_idle();
    reg_write(32'd17);
    reg_check();
    reg_write(32'd31);
    reg_check();
  endtask

  // one slot: capacity refusal with the slot ready and with it suspended
  task automatic test_single_slot();
    wait_idle();
    reg_write(32'hFFFF_FFE1);
    reg_check();
    send_cmd(make_cmd(OP_CREATE, 8'd0, 8'd1, 8'd0));
    send_cmd(make_cmd(OP_CREATE, 8'd0, 8'd2, 8'd0));
    send_cmd(make_cmd(OP_SUSPEND, 8'd0, 8'd0, last_id));
    send_cmd(make_cmd(OP_CREATE, 8'd0, 8'd3, 8'd0));
    send_cmd(make_cmd(OP_UNSUSPEND, last_id, 8'd0, 8'd1));
  endtask

  // random traffic at one capacity
  task automatic test_random_traffic(input int unsigned slots);
    wait_idle();
    reg_write({27'($urandom), 5'(slots)});
    reg_check();
    repeat (PHASE_ITEMS) send_cmd(random_cmd());
  endtask

  // use up all ids, then creates stay refused even in an emptied table
  task automatic test_id_exhaustion();
    while (last_id != LAST_ID) begin
      if (slot_limit != TABLE_DEPTH || ready_top + slot_limit - susp_base == slot_limit) begin
        wait_idle();
        reg_write(TABLE_DEPTH);
      end
      send_cmd(make_cmd(OP_CREATE, ID_W'($urandom_range(0, 255)),
                        PRIO_W'($urandom_range(0, 255)), ID_W'($urandom_range(0, 255))));
    end
    send_cmd(make_cmd(OP_SUSPEND, thread_slots[0].id, 8'd0, 8'd1));
    send_cmd(make_cmd(OP_CREATE, 8'd0, 8'd9, 8'd0));
    wait_idle();
    reg_write(TABLE_DEPTH);
    reg_check();
    send_cmd(make_cmd(OP_CREATE, 8'd0, 8'd9, 8'd0));
    send_cmd(make_cmd(OP_SUSPEND, 8'd0, 8'd0, LAST_ID));
  endtask

  // test sequence
  initial begin
    thread_slots = new[TABLE_DEPTH];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_empty_table();
    test_create();
    test_suspend();
    test_unsuspend();
    test_no_table();
    test_single_slot();
    test_random_traffic(TABLE_DEPTH);
    test_random_traffic(2);
    test_random_traffic($urandom_range(3, TABLE_DEPTH - 1));
    test_random_traffic(1);
    test_random_traffic(TABLE_DEPTH);
    test_id_exhaustion();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
